[hw/rtl/histogram3d_bin_accumulator_top_defines.svh]
// ----------------------------------------------------------------------------
// histogram3d_bin_accumulator_top_defines
// Assertion macros shared by the histogram bin accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM3D_BIN_ACCUMULATOR_TOP_DEFINES_SVH
`define HISTOGRAM3D_BIN_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define H3B_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define H3B_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/h3b_pkg.sv]
// ----------------------------------------------------------------------------
// h3b_pkg
// Shared types, codes and helpers of the 3-D histogram bin accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h3b_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned BIN_W   = 48;
    localparam int unsigned CNT_W   = 9;

    localparam logic [2:0] MODE_STRICT  = 3'd0;
    localparam logic [2:0] MODE_CLAMPED = 3'd1;
    localparam logic [2:0] MODE_READ    = 3'd2;
    localparam logic [2:0] MODE_EDGE    = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [1:0] CFG_X_BINS = 2'd0;
    localparam logic [1:0] CFG_Y_BINS = 2'd1;
    localparam logic [1:0] CFG_Z_BINS = 2'd2;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    // Handshake of the search unit back to the sequencer.
    typedef struct packed {
        logic done;
        logic in_range;
    } t_search_status;

    // Clamp a raw bin count register to 1 .. maxb.
    function automatic logic [CNT_W-1:0] eff_bins(input logic [4:0] raw,
                                                  input int unsigned maxb);
        logic [CNT_W-1:0] res;
        if (raw == 5'd0) begin
            res = CNT_W'(1);
        end else if (32'(raw) > maxb) begin
            res = CNT_W'(maxb);
        end else begin
            res = CNT_W'(raw);
        end
        return res;
    endfunction

endpackage

[hw/rtl/h3b_ram.sv]
// ----------------------------------------------------------------------------
// h3b_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h3b_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/h3b_search.sv]
// ----------------------------------------------------------------------------
// h3b_search
// Edge tables and one shared signed comparator stepping a binary search
// over the x, y and z axes in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "histogram3d_bin_accumulator_top_defines.svh"

module h3b_search #(
    parameter int unsigned MAX_X_BINS = 16,
    parameter int unsigned MAX_Y_BINS = 16,
    parameter int unsigned MAX_Z_BINS = 16,
    parameter int unsigned CW         = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_clamp,
    input  logic signed [31:0]            i_x_coord,
    input  logic signed [31:0]            i_y_coord,
    input  logic signed [31:0]            i_z_coord,
    input  logic [CW-1:0]                 i_n_x,
    input  logic [CW-1:0]                 i_n_y,
    input  logic [CW-1:0]                 i_n_z,
    input  logic                          i_edge_we,
    input  h3b_pkg::t_axis                i_edge_axis,
    input  logic [CW-1:0]                 i_edge_idx,
    input  logic signed [31:0]            i_edge_val,
    output h3b_pkg::t_search_status       o_status,
    output logic [CW-1:0]                 o_bin_x,
    output logic [CW-1:0]                 o_bin_y,
    output logic [CW-1:0]                 o_bin_z
);

    localparam int unsigned XIW = $clog2(MAX_X_BINS + 1);
    localparam int unsigned YIW = $clog2(MAX_Y_BINS + 1);
    localparam int unsigned ZIW = $clog2(MAX_Z_BINS + 1);

    typedef enum logic [3:0] {
        SS_IDLE = 4'b0001,
        SS_LOW  = 4'b0010,
        SS_HIGH = 4'b0100,
        SS_MID  = 4'b1000
    } t_sstate;

    t_sstate            r_state, n_state;
    h3b_pkg::t_axis     r_axis, n_axis;
    logic               r_clamp;
    logic signed [31:0] r_coord [3];
    logic [CW-1:0]      r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]      r_bin [3];
    logic [CW-1:0]      n_bin_val;
    logic               n_bin_we;
    logic               r_done, n_done, r_inside, n_inside;

    logic signed [31:0] r_xe [MAX_X_BINS + 1];
    logic signed [31:0] r_ye [MAX_Y_BINS + 1];
    logic signed [31:0] r_ze [MAX_Z_BINS + 1];

    logic [CW-1:0]      w_n, w_mid, w_sel;
    logic [CW:0]        w_sum;
    logic signed [31:0] w_v, w_edge;
    logic               w_ge;
    logic               w_last_axis;

    // Operand selection for the shared comparator.
    always_comb begin
        w_sum = {1'b0, r_lo} + {1'b0, r_hi};
        w_mid = w_sum[CW:1];
        case (r_axis)
            h3b_pkg::AX_X: begin w_n = i_n_x; w_v = r_coord[0]; end
            h3b_pkg::AX_Y: begin w_n = i_n_y; w_v = r_coord[1]; end
            h3b_pkg::AX_Z: begin w_n = i_n_z; w_v = r_coord[2]; end
            default:       begin w_n = i_n_x; w_v = r_coord[0]; end
        endcase
        case (r_state)
            SS_LOW:  w_sel = '0;
            SS_HIGH: w_sel = w_n;
            SS_MID:  w_sel = w_mid;
            default: w_sel = '0;
        endcase
        case (r_axis)
            h3b_pkg::AX_X: w_edge = r_xe[w_sel[XIW-1:0]];
            h3b_pkg::AX_Y: w_edge = r_ye[w_sel[YIW-1:0]];
            h3b_pkg::AX_Z: w_edge = r_ze[w_sel[ZIW-1:0]];
            default:       w_edge = r_xe[w_sel[XIW-1:0]];
        endcase
        w_ge        = (w_v >= w_edge);
        w_last_axis = (r_axis == h3b_pkg::AX_Z);
    end

    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_bin_we  = 1'b0;
        n_bin_val = '0;
        n_done    = 1'b0;
        n_inside  = r_inside;
        case (r_state)
            SS_IDLE: begin
                if (i_start) begin
                    n_state  = SS_LOW;
                    n_axis   = h3b_pkg::AX_X;
                    n_inside = 1'b1;
                end
            end
            SS_LOW: begin
                if (!w_ge) begin
                    n_bin_we  = 1'b1;
                    n_bin_val = '0;
                    if (!r_clamp) begin
                        n_inside = 1'b0;
                        n_done   = 1'b1;
                        n_state  = SS_IDLE;
                    end else if (w_last_axis) begin
                        n_done  = 1'b1;
                        n_state = SS_IDLE;
                    end else begin
                        n_axis  = h3b_pkg::t_axis'(r_axis + 2'd1);
                        n_state = SS_LOW;
                    end
                end else begin
                    n_state = SS_HIGH;
                end
            end
            SS_HIGH: begin
                n_lo = '0;
                n_hi = w_n;
                if (w_ge) begin
                    n_bin_we  = 1'b1;
                    n_bin_val = w_n - CW'(1);
                    if (!r_clamp) begin
                        n_inside = 1'b0;
                        n_done   = 1'b1;
                        n_state  = SS_IDLE;
                    end else if (w_last_axis) begin
                        n_done  = 1'b1;
                        n_state = SS_IDLE;
                    end else begin
                        n_axis  = h3b_pkg::t_axis'(r_axis + 2'd1);
                        n_state = SS_LOW;
                    end
                end else if (w_n > CW'(1)) begin
                    n_state = SS_MID;
                end else begin
                    n_bin_we  = 1'b1;
                    n_bin_val = '0;
                    if (w_last_axis) begin
                        n_done  = 1'b1;
                        n_state = SS_IDLE;
                    end else begin
                        n_axis  = h3b_pkg::t_axis'(r_axis + 2'd1);
                        n_state = SS_LOW;
                    end
                end
            end
            SS_MID: begin
                if (w_ge) begin
                    n_lo = w_mid;
                end else begin
                    n_hi = w_mid;
                end
                if (n_hi - n_lo <= CW'(1)) begin
                    n_bin_we  = 1'b1;
                    n_bin_val = n_lo;
                    if (w_last_axis) begin
                        n_done  = 1'b1;
                        n_state = SS_IDLE;
                    end else begin
                        n_axis  = h3b_pkg::t_axis'(r_axis + 2'd1);
                        n_state = SS_LOW;
                    end
                end
            end
            default: begin
                n_state = SS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SS_IDLE;
            r_axis   <= h3b_pkg::AX_X;
            r_done   <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_done   <= n_done;
            r_inside <= n_inside;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_start && r_state == SS_IDLE) begin
            r_clamp    <= i_clamp;
            r_coord[0] <= i_x_coord;
            r_coord[1] <= i_y_coord;
            r_coord[2] <= i_z_coord;
        end
        if (n_bin_we) begin
            r_bin[r_axis] <= n_bin_val;
        end
    end

    // Edge tables: edge n resets to n in Q16.16.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n <= int'(MAX_X_BINS); n++) r_xe[n] <= 32'(n) <<< 16;
            for (int n = 0; n <= int'(MAX_Y_BINS); n++) r_ye[n] <= 32'(n) <<< 16;
            for (int n = 0; n <= int'(MAX_Z_BINS); n++) r_ze[n] <= 32'(n) <<< 16;
        end else if (i_edge_we) begin
            case (i_edge_axis)
                h3b_pkg::AX_X: r_xe[i_edge_idx[XIW-1:0]] <= i_edge_val;
                h3b_pkg::AX_Y: r_ye[i_edge_idx[YIW-1:0]] <= i_edge_val;
                h3b_pkg::AX_Z: r_ze[i_edge_idx[ZIW-1:0]] <= i_edge_val;
                default: ;
            endcase
        end
    end

    assign o_status.done     = r_done;
    assign o_status.in_range = r_inside;
    assign o_bin_x           = r_bin[0];
    assign o_bin_y           = r_bin[1];
    assign o_bin_z           = r_bin[2];

    `H3B_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == SS_IDLE, "search done while busy")
    `H3B_ASSERT_IMP(a_mid_span, i_clk, i_rst_n, r_state == SS_MID, r_hi > r_lo + CW'(1), "search span collapsed")

endmodule

[hw/rtl/histogram3d_bin_accumulator_top.sv]
// ----------------------------------------------------------------------------
// histogram3d_bin_accumulator_top
// Three-axis weighted histogram: per-axis binary search, saturating 48-bit
// bin update, bin read, edge load and clear.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | sink      | i_in_valid / o_in_ready     | mode, coords, weight, read and edge fields
//  out     | source    | o_out_valid / i_out_ready   | status, found_i/j/k, bin_value
//  cfg     | sink      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data (bin counts)
//
//  Accumulate: accept, then on the shared comparator the low edge, the high
//  edge and a binary search per axis, pick-up of the search result, one RAM
//  read and one update step, then the result. Read bin goes through the RAM
//  read and update before the result, edge load and bad codes straight to it.
//  Clear all and reset sweep the bin RAM one entry a cycle over all
//  MAX_X_BINS*MAX_Y_BINS*MAX_Z_BINS entries (4096 by default), o_in_ready low.
//  One item at a time: o_in_ready is low from accept until the result is taken.
//  Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "histogram3d_bin_accumulator_top_defines.svh"

module histogram3d_bin_accumulator_top #(
    parameter int unsigned MAX_X_BINS = 16,
    parameter int unsigned MAX_Y_BINS = 16,
    parameter int unsigned MAX_Z_BINS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_z_coord,
    input  logic signed [31:0] i_weight,
    input  logic [3:0]         i_read_i,
    input  logic [3:0]         i_read_j,
    input  logic [3:0]         i_read_k,
    input  logic [1:0]         i_edge_axis,
    input  logic [4:0]         i_edge_index,
    input  logic signed [31:0] i_edge_value,
    // Result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [3:0]         o_found_i,
    output logic [3:0]         o_found_j,
    output logic [3:0]         o_found_k,
    output logic signed [47:0] o_bin_value,
    // Configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data
);

    localparam int unsigned MAX_XY  = (MAX_X_BINS > MAX_Y_BINS) ? MAX_X_BINS : MAX_Y_BINS;
    localparam int unsigned MAX_ALL = (MAX_XY > MAX_Z_BINS) ? MAX_XY : MAX_Z_BINS;
    localparam int unsigned CW      = $clog2(MAX_ALL + 1);
    localparam int unsigned DEPTH   = MAX_X_BINS * MAX_Y_BINS * MAX_Z_BINS;
    localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] YZ_STRIDE = AW'(MAX_Y_BINS * MAX_Z_BINS);
    localparam logic [AW-1:0] Z_STRIDE  = AW'(MAX_Z_BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic signed [47:0] BIN_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] BIN_MIN = {1'b1, {47{1'b0}}};

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_SRCH = 6'b000100,
        S_RD   = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state             r_state;
    logic [4:0]         r_x_bins, r_y_bins, r_z_bins;
    logic [AW-1:0]      r_clr_addr;
    logic               r_clr_reply;
    logic [AW-1:0]      r_addr;
    logic               r_acc;
    logic signed [31:0] r_weight;
    logic [1:0]         r_status;
    logic [3:0]         r_fi, r_fj, r_fk;
    logic signed [47:0] r_val;

    logic [CW-1:0]      w_nx, w_ny, w_nz;
    logic               w_in_acc, w_edge_ok, w_edge_we, w_start, w_read_ok;
    h3b_pkg::t_search_status w_srch;
    logic [CW-1:0]      w_bx, w_by, w_bz;
    logic [AW-1:0]      w_srch_addr, w_read_addr;
    logic               w_ram_we, w_ram_re;
    logic [AW-1:0]      w_ram_waddr;
    logic [47:0]        w_ram_wdata, w_rdata;
    logic signed [48:0] w_sum;
    logic signed [47:0] w_sat;

    // Effective bin counts: zero acts as one, above the maximum as the maximum.
    assign w_nx = CW'(h3b_pkg::eff_bins(r_x_bins, MAX_X_BINS));
    assign w_ny = CW'(h3b_pkg::eff_bins(r_y_bins, MAX_Y_BINS));
    assign w_nz = CW'(h3b_pkg::eff_bins(r_z_bins, MAX_Z_BINS));

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Edge target check: axis code three or index past the table is rejected.
    always_comb begin
        case (i_edge_axis)
            h3b_pkg::AX_X: w_edge_ok = (32'(i_edge_index) <= MAX_X_BINS);
            h3b_pkg::AX_Y: w_edge_ok = (32'(i_edge_index) <= MAX_Y_BINS);
            h3b_pkg::AX_Z: w_edge_ok = (32'(i_edge_index) <= MAX_Z_BINS);
            default:       w_edge_ok = 1'b0;
        endcase
    end

    assign w_edge_we = w_in_acc && (i_mode == h3b_pkg::MODE_EDGE) && w_edge_ok;
    assign w_start   = w_in_acc && (i_mode inside {h3b_pkg::MODE_STRICT,
                                                   h3b_pkg::MODE_CLAMPED});
    assign w_read_ok = (32'(i_read_i) < 32'(w_nx)) && (32'(i_read_j) < 32'(w_ny)) &&
                       (32'(i_read_k) < 32'(w_nz));

    // Fixed address i*MAX_Y*MAX_Z + j*MAX_Z + k.
    assign w_srch_addr = AW'(w_bx) * YZ_STRIDE + AW'(w_by) * Z_STRIDE + AW'(w_bz);
    assign w_read_addr = AW'(i_read_i) * YZ_STRIDE + AW'(i_read_j) * Z_STRIDE +
                         AW'(i_read_k);

    // Saturating add of the weight to the bin just read.
    always_comb begin
        w_sum = {w_rdata[47], w_rdata} + {{17{r_weight[31]}}, r_weight};
        if (w_sum[48] != w_sum[47]) begin
            w_sat = w_sum[48] ? BIN_MIN : BIN_MAX;
        end else begin
            w_sat = w_sum[47:0];
        end
    end

    assign w_ram_we    = (r_state == S_CLR) || ((r_state == S_UPD) && r_acc);
    assign w_ram_waddr = (r_state == S_CLR) ? r_clr_addr : r_addr;
    assign w_ram_wdata = (r_state == S_CLR) ? '0 : w_sat;
    assign w_ram_re    = (r_state == S_RD);

    h3b_search #(
        .MAX_X_BINS (MAX_X_BINS),
        .MAX_Y_BINS (MAX_Y_BINS),
        .MAX_Z_BINS (MAX_Z_BINS),
        .CW         (CW)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_clamp     (i_mode == h3b_pkg::MODE_CLAMPED),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_z_coord   (i_z_coord),
        .i_n_x       (w_nx),
        .i_n_y       (w_ny),
        .i_n_z       (w_nz),
        .i_edge_we   (w_edge_we),
        .i_edge_axis (h3b_pkg::t_axis'(i_edge_axis)),
        .i_edge_idx  (CW'(i_edge_index)),
        .i_edge_val  (i_edge_value),
        .o_status    (w_srch),
        .o_bin_x     (w_bx),
        .o_bin_y     (w_by),
        .o_bin_z     (w_bz)
    );

    h3b_ram #(
        .WIDTH (h3b_pkg::BIN_W),
        .DEPTH (DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Configuration registers: raw values kept, clamped on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_bins <= 5'd16;
            r_y_bins <= 5'd16;
            r_z_bins <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                h3b_pkg::CFG_X_BINS: r_x_bins <= i_cfg_data;
                h3b_pkg::CFG_Y_BINS: r_y_bins <= i_cfg_data;
                h3b_pkg::CFG_Z_BINS: r_z_bins <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer. Reset starts with a sweep that zeroes the bin RAM.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= r_clr_reply ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_mode)
                            h3b_pkg::MODE_STRICT,
                            h3b_pkg::MODE_CLAMPED: r_state <= S_SRCH;
                            h3b_pkg::MODE_READ:    r_state <= w_read_ok ? S_RD : S_OUT;
                            h3b_pkg::MODE_CLEAR: begin
                                r_state     <= S_CLR;
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                            end
                            default:               r_state <= S_OUT;
                        endcase
                    end
                end
                S_SRCH: begin
                    if (w_srch.done) begin
                        r_state <= w_srch.in_range ? S_RD : S_OUT;
                    end
                end
                S_RD:  r_state <= S_UPD;
                S_UPD: r_state <= S_OUT;
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_weight <= i_weight;
                    r_acc    <= 1'b0;
                    r_fi     <= '0;
                    r_fj     <= '0;
                    r_fk     <= '0;
                    r_val    <= '0;
                    r_status <= h3b_pkg::ST_OK;
                    case (i_mode)
                        h3b_pkg::MODE_STRICT,
                        h3b_pkg::MODE_CLAMPED: r_acc <= 1'b1;
                        h3b_pkg::MODE_READ: begin
                            r_fi     <= i_read_i;
                            r_fj     <= i_read_j;
                            r_fk     <= i_read_k;
                            r_addr   <= w_read_addr;
                            r_status <= w_read_ok ? h3b_pkg::ST_OK : h3b_pkg::ST_BAD_INDEX;
                        end
                        h3b_pkg::MODE_EDGE:
                            r_status <= w_edge_ok ? h3b_pkg::ST_OK : h3b_pkg::ST_BAD_INDEX;
                        h3b_pkg::MODE_CLEAR: r_status <= h3b_pkg::ST_OK;
                        default: r_status <= h3b_pkg::ST_BAD_INDEX;
                    endcase
                end
            end
            S_SRCH: begin
                if (w_srch.done) begin
                    if (w_srch.in_range) begin
                        r_addr <= w_srch_addr;
                        r_fi   <= w_bx[3:0];
                        r_fj   <= w_by[3:0];
                        r_fk   <= w_bz[3:0];
                    end else begin
                        r_status <= h3b_pkg::ST_OUTSIDE;
                    end
                end
            end
            S_UPD: begin
                r_val <= r_acc ? w_sat : $signed(w_rdata);
            end
            default: ;
        endcase
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_found_i   = r_fi;
    assign o_found_j   = r_fj;
    assign o_found_k   = r_fk;
    assign o_bin_value = r_val;

    `H3B_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "accepting while a result is pending")
    `H3B_ASSERT_IMP(a_done_in_srch, i_clk, i_rst_n, w_srch.done, r_state == S_SRCH, "search done outside search state")
    `H3B_ASSERT_NXT(a_clear_starts, i_clk, i_rst_n, w_in_acc && i_mode == h3b_pkg::MODE_CLEAR, r_state == S_CLR && r_clr_addr == '0, "clear item did not start a sweep")
    `H3B_ASSERT_IMP(a_write_ctx, i_clk, i_rst_n, w_ram_we && r_state != S_CLR, r_state == S_UPD && r_status == h3b_pkg::ST_OK, "bin write outside update")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram bin accumulator testbench
// Drives random and directed points, bin reads, edge loads and clears through
// the input channel. A model of the bin store and the edges in the bench works
// out each result and checks it field by field against what the block returns.
// ----------------------------------------------------------------------------

module testbench;

    // Unknown mode codes, all answered with a bad index status
    localparam logic [2:0] MODE_BAD_LO = 3'd5;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;
    localparam int AXIS_BAD      = 3;
    localparam int MAX_BINS      = 16;
    localparam int STORE_DEPTH   = MAX_BINS * MAX_BINS * MAX_BINS;
    localparam int IDLE_LIMIT    = 20000;  // clear sweep plus the long stall
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_STALL    = 400;
    localparam int PHASE_ITEMS   = 170;

    typedef struct {
        logic [2:0]         mode;
        logic signed [31:0] x, y, z, w;
        logic [3:0]         ri, rj, rk;
        logic [1:0]         axis;
        logic [4:0]         eidx;
        logic signed [31:0] evalue;
    } t_point_item;

    typedef struct {
        logic [1:0]         status;
        logic [3:0]         fi, fj, fk;
        logic signed [47:0] value;
    } t_bin_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Input channel
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         in_mode = '0;
    logic signed [31:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
    logic [3:0]         in_ri = '0, in_rj = '0, in_rk = '0;
    logic [1:0]         in_axis = '0;
    logic [4:0]         in_eidx = '0;
    logic signed [31:0] in_evalue = '0;

    // Result channel
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [3:0]         o_found_i, o_found_j, o_found_k;
    logic signed [47:0] o_bin_value;

    // Configuration channel
    logic       cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;

    // Shadow of the block's state
    logic signed [47:0] bin_mirror [STORE_DEPTH];
    logic signed [31:0] edge_tab [3][MAX_BINS + 1];
    logic [4:0]         bins_reg [3];

    t_point_item pending_items[$];
    t_point_item on_bus;
    t_bin_result expected_bins[$];
    bit          failed = 1'b0;
    int          results_seen = 0;

    histogram3d_bin_accumulator_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (in_mode),
        .i_x_coord    (in_x),
        .i_y_coord    (in_y),
        .i_z_coord    (in_z),
        .i_weight     (in_w),
        .i_read_i     (in_ri),
        .i_read_j     (in_rj),
        .i_read_k     (in_rk),
        .i_edge_axis  (in_axis),
        .i_edge_index (in_eidx),
        .i_edge_value (in_evalue),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_status     (o_status),
        .o_found_i    (o_found_i),
        .o_found_j    (o_found_j),
        .o_found_k    (o_found_k),
        .o_bin_value  (o_bin_value),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int bins_in_use(input int ax);
        if (bins_reg[ax] == 5'd0) return 1;
        if (int'(bins_reg[ax]) > MAX_BINS) return MAX_BINS;
        return int'(bins_reg[ax]);
    endfunction

    // Binary search on one axis; false when strict and the point is outside
    function automatic bit find_bin(input int ax, input logic signed [31:0] v,
                                    input bit clamp, output int b);
        int n, lo, hi, mid;
        n  = bins_in_use(ax);
        lo = 0;
        hi = n;
        if (v < edge_tab[ax][0]) begin
            b = 0;
            return clamp;
        end
        if (v >= edge_tab[ax][n]) begin
            b = n - 1;
            return clamp;
        end
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (v >= edge_tab[ax][mid]) lo = mid;
            else hi = mid;
        end
        b = lo;
        return 1'b1;
    endfunction

    function automatic t_bin_result bin_update(input t_point_item it);
        t_bin_result r;
        int     bi, bj, bk, addr;
        bit     ok;
        longint sum;
        r = '{h3b_pkg::ST_OK, 4'd0, 4'd0, 4'd0, 48'sd0};
        case (it.mode)
            h3b_pkg::MODE_STRICT, h3b_pkg::MODE_CLAMPED: begin
                ok = find_bin(h3b_pkg::AX_X, it.x, it.mode == h3b_pkg::MODE_CLAMPED, bi);
                ok = find_bin(h3b_pkg::AX_Y, it.y, it.mode == h3b_pkg::MODE_CLAMPED, bj) && ok;
                ok = find_bin(h3b_pkg::AX_Z, it.z, it.mode == h3b_pkg::MODE_CLAMPED, bk) && ok;
                if (!ok) begin
                    r.status = h3b_pkg::ST_OUTSIDE;
                end else begin
                    addr = (bi * MAX_BINS + bj) * MAX_BINS + bk;
                    sum = longint'(bin_mirror[addr]) + longint'(it.w);
                    if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
                    if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
                    bin_mirror[addr] = 48'(sum);
                    r = '{h3b_pkg::ST_OK, 4'(bi), 4'(bj), 4'(bk), 48'(sum)};
                end
            end
            h3b_pkg::MODE_READ: begin
                r.fi = it.ri;
                r.fj = it.rj;
                r.fk = it.rk;
                if (int'(it.ri) >= bins_in_use(h3b_pkg::AX_X)
                        || int'(it.rj) >= bins_in_use(h3b_pkg::AX_Y)
                        || int'(it.rk) >= bins_in_use(h3b_pkg::AX_Z)) begin
                    r.status = h3b_pkg::ST_BAD_INDEX;
                end else begin
                    r.value = bin_mirror[(int'(it.ri) * MAX_BINS + int'(it.rj)) * MAX_BINS
                                         + int'(it.rk)];
                end
            end
            h3b_pkg::MODE_EDGE: begin
                if (int'(it.axis) == AXIS_BAD || int'(it.eidx) > MAX_BINS) begin
                    r.status = h3b_pkg::ST_BAD_INDEX;
                end else begin
                    edge_tab[it.axis][it.eidx] = it.evalue;
                end
            end
            h3b_pkg::MODE_CLEAR: begin
                foreach (bin_mirror[a]) bin_mirror[a] = '0;
            end
            default: begin
                r.status = h3b_pkg::ST_BAD_INDEX;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of items with random gaps; predict on acceptance
    // ------------------------------------------------------------------------
    int burst_left = 4;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_bins.push_back(bin_update(on_bus));
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    on_bus = pending_items.pop_front();
                    in_mode   <= on_bus.mode;
                    in_x      <= on_bus.x;
                    in_y      <= on_bus.y;
                    in_z      <= on_bus.z;
                    in_w      <= on_bus.w;
                    in_ri     <= on_bus.ri;
                    in_rj     <= on_bus.rj;
                    in_rk     <= on_bus.rk;
                    in_axis   <= on_bus.axis;
                    in_eidx   <= on_bus.eidx;
                    in_evalue <= on_bus.evalue;
                    in_valid  <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        // Some bursts follow each other with no gap at all
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results, stall on its own pattern, one long hold-off
    // ------------------------------------------------------------------------
    int  stall_window = 0;
    bit  stall_often = 1'b0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    t_bin_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (expected_bins.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d bin %0d",
                             $realtime, o_status, o_bin_value);
                    failed = 1'b1;
                end else begin
                    want = expected_bins.pop_front();
                    if (o_status !== want.status || o_found_i !== want.fi
                            || o_found_j !== want.fj || o_found_k !== want.fk
                            || o_bin_value !== want.value) begin
                        $display("%0t: mismatch expected st=%0d ijk=%0d,%0d,%0d v=%0d",
                                 $realtime, want.status, want.fi, want.fj, want.fk,
                                 want.value);
                        $display("%0t:          actual   st=%0d ijk=%0d,%0d,%0d v=%0d",
                                 $realtime, o_status, o_found_i, o_found_j, o_found_k,
                                 o_bin_value);
                        failed = 1'b1;
                    end
                end
            end
            // Hold off for a long stretch once, while the sender keeps offering
            if (!held_once && results_seen == 300) begin
                held_once = 1'b1;
                hold_left = LONG_STALL;
            end
            if (stall_window == 0) begin
                stall_window = $urandom_range(16, 80);
                stall_often  = $urandom_range(0, 1);
            end
            stall_window--;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_often) begin
                out_ready <= ($urandom_range(0, 2) != 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic t_point_item blank_item(input logic [2:0] mode);
        t_point_item it;
        it = '{mode, 32'sd0, 32'sd0, 32'sd0, 32'sh10000, 4'd0, 4'd0, 4'd0, 2'd0, 5'd0,
               32'sd0};
        return it;
    endfunction

    function automatic t_point_item point(input logic [2:0] mode, input int x, input int y,
                                          input int z, input int w);
        t_point_item it;
        it = blank_item(mode);
        it.x = x;
        it.y = y;
        it.z = z;
        it.w = w;
        return it;
    endfunction

    function automatic t_point_item edge_load(input int ax, input int idx, input int v);
        t_point_item it;
        it = blank_item(h3b_pkg::MODE_EDGE);
        it.axis   = 2'(ax);
        it.eidx   = 5'(idx);
        it.evalue = v;
        return it;
    endfunction

    function automatic t_point_item bin_read(input int i, input int j, input int k);
        t_point_item it;
        it = blank_item(h3b_pkg::MODE_READ);
        it.ri = 4'(i);
        it.rj = 4'(j);
        it.rk = 4'(k);
        return it;
    endfunction

    // Coordinate near an edge of the axis, or anywhere at all
    function automatic logic signed [31:0] pick_coord(input int ax);
        int idx;
        idx = $urandom_range(0, MAX_BINS);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return edge_tab[ax][idx];
            2: return edge_tab[ax][idx] - 1;
            default: return edge_tab[ax][idx] + $urandom_range(0, 32'h1_0000);
        endcase
    endfunction

    function automatic t_point_item random_item();
        t_point_item it;
        int sel;
        sel = $urandom_range(0, 199);
        if (sel < 80) begin
            it = point(h3b_pkg::MODE_STRICT, pick_coord(h3b_pkg::AX_X),
                       pick_coord(h3b_pkg::AX_Y), pick_coord(h3b_pkg::AX_Z), 0);
        end else if (sel < 130) begin
            it = point(h3b_pkg::MODE_CLAMPED, pick_coord(h3b_pkg::AX_X),
                       pick_coord(h3b_pkg::AX_Y), pick_coord(h3b_pkg::AX_Z), 0);
        end else if (sel < 160) begin
            it = bin_read($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (sel < 190) begin
            // Mostly in-range edge loads; a few with any target
            if ($urandom_range(0, 3) == 0)
                it = edge_load($urandom_range(0, 3), $urandom_range(0, 31), $urandom);
            else
                it = edge_load($urandom_range(0, 2), $urandom_range(0, MAX_BINS),
                               int'($urandom_range(0, 20 * 32'h1_0000)) - 32'sh2_0000);
        end else if (sel < 199) begin
            it = blank_item(3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI)));
        end else begin
            it = blank_item(h3b_pkg::MODE_CLEAR);
        end
        // Randomize the don't-care read index fields of non-read items too
        if (it.mode != h3b_pkg::MODE_READ) begin
            it.ri = $urandom;
            it.rj = $urandom;
            it.rk = $urandom;
        end
        case ($urandom_range(0, 3))
            0: it.w = $urandom;
            1: it.w = -32'sh1_0000;
            default: it.w = 32'sh1_0000;
        endcase
        return it;
    endfunction

    // Load a full ascending edge set on one axis with random start and step
    task automatic queue_ascending_edges(input int ax);
        int start, step;
        start = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
        step  = $urandom_range(1, 32'h3_0000);
        for (int n = 0; n <= MAX_BINS; n++) begin
            pending_items.push_back(edge_load(ax, n, start + n * step));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_bins.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bins(input logic [1:0] idx, input logic [4:0] value);
        @(posedge i_clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bins_reg[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_bins(input logic [4:0] nx, input logic [4:0] ny,
                            input logic [4:0] nz);
        write_bins(h3b_pkg::CFG_X_BINS, nx);
        write_bins(h3b_pkg::CFG_Y_BINS, ny);
        write_bins(h3b_pkg::CFG_Z_BINS, nz);
    endtask

    initial begin
        logic [4:0] phase_bins [6][3];
        phase_bins = '{'{5'd1, 5'd1, 5'd1}, '{5'd0, 5'd31, 5'd5}, '{5'd31, 5'd0, 5'd16},
                       '{5'd17, 5'd2, 5'd3}, '{5'd7, 5'd12, 5'd9}, '{5'd16, 5'd16, 5'd16}};

        // Shadow state after reset
        foreach (bin_mirror[a]) bin_mirror[a] = '0;
        for (int ax = 0; ax < 3; ax++) begin
            bins_reg[ax] = 5'd16;
            for (int n = 0; n <= MAX_BINS; n++) edge_tab[ax][n] = n * 32'sh1_0000;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: range ends, clamping, extreme weights, bad targets, clear
        pending_items.push_back(point(h3b_pkg::MODE_STRICT, 0, 0, 0, 32'sh1_0000));
        pending_items.push_back(point(h3b_pkg::MODE_STRICT, 32'h000F_FFFF, 32'h000F_FFFF,
                                      32'h000F_FFFF, 32'sh7FFF_FFFF));
        pending_items.push_back(point(h3b_pkg::MODE_STRICT, 32'h000F_FFFF, 32'h000F_FFFF,
                                      32'h000F_FFFF, 32'sh7FFF_FFFF));
        pending_items.push_back(point(h3b_pkg::MODE_STRICT, -1, 0, 0, 32'sh1_0000));
        pending_items.push_back(point(h3b_pkg::MODE_STRICT, 0, 32'h0010_0000, 0,
                                      32'sh1_0000));
        pending_items.push_back(point(h3b_pkg::MODE_CLAMPED, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                      32'h0010_0000, -32'sh8000_0000));
        pending_items.push_back(point(h3b_pkg::MODE_CLAMPED, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                      -1, -32'sh8000_0000));
        pending_items.push_back(point(h3b_pkg::MODE_STRICT, 32'h0007_8000, 32'h0003_0000,
                                      32'h0002_FFFF, 32'sh1_0000));
        pending_items.push_back(bin_read(0, 0, 0));
        pending_items.push_back(bin_read(15, 15, 15));
        pending_items.push_back(bin_read(0, 15, 0));
        pending_items.push_back(edge_load(AXIS_BAD, 0, 5));
        pending_items.push_back(edge_load(h3b_pkg::AX_X, 17, 5));
        pending_items.push_back(edge_load(h3b_pkg::AX_Z, 31, 5));
        pending_items.push_back(edge_load(h3b_pkg::AX_Y, 16, 32'sh7FFF_FFFF));
        pending_items.push_back(edge_load(h3b_pkg::AX_X, 0, 32'sh8000_0000));
        pending_items.push_back(point(h3b_pkg::MODE_STRICT, 32'sh8000_0000, 32'h0010_0000,
                                      0, 32'sh1_0000));
        pending_items.push_back(blank_item(MODE_BAD_LO));
        pending_items.push_back(blank_item(3'd6));
        pending_items.push_back(blank_item(MODE_BAD_HI));
        pending_items.push_back(blank_item(h3b_pkg::MODE_CLEAR));
        pending_items.push_back(bin_read(15, 15, 15));
        wait_drained();

        // Random phases, each under its own bin counts, with fresh edge sets on random axes
        for (int ph = 0; ph < 6; ph++) begin
            set_bins(phase_bins[ph][0], phase_bins[ph][1], phase_bins[ph][2]);
            for (int ax = 0; ax < 3; ax++) begin
                if ($urandom_range(0, 2) != 0) queue_ascending_edges(ax);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_item());
            wait_drained();
        end

        if (expected_bins.size() == 0 && !failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/h3b_pkg.sv
hw/rtl/h3b_ram.sv
hw/rtl/h3b_search.sv
hw/rtl/histogram3d_bin_accumulator_top.sv
test/testbench.sv
